// ----- rtl/core/lsq_pkg.sv -----
// Package for the lid sensor event qualifier.
// Holds the timer width, register and operation codes, and the config bundle.
// No dependencies; every other file of the block uses it.
package lsq_pkg;

	// Width of the close and hold countdowns.
	localparam int TIMER_BITS = 16;
	localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;

	// Width of the delay registers and of the config write data.
	localparam int DELAY_W  = 16;
	localparam int CFG_IDX_W = 2;

	// Register indexes on the config channel.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ENABLED     = 2'd0,
		REG_ACTIVE_HIGH = 2'd1,
		REG_CLOSE_DELAY = 2'd2,
		REG_HOLD_WINDOW = 2'd3
	} cfg_reg_t;

	// Item operation codes.
	localparam logic OP_EDGE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// Reset values of the registers.
	localparam logic [DELAY_W-1:0] CLOSE_DELAY_RST = 16'd250;
	localparam logic [DELAY_W-1:0] HOLD_WINDOW_RST = 16'd3000;

	// Current register contents, as seen by the datapath.
	typedef struct packed {
		logic               enabled;
		logic               active_high;
		logic [DELAY_W-1:0] close_delay;
		logic [DELAY_W-1:0] hold_window;
	} cfg_t;

	// Controls for one countdown for a single beat.
	typedef struct packed {
		logic tick;
		logic arm;
		logic clear;
	} timer_ctl_t;

	// Delay loaded into a countdown, saturated at the counter's largest value.
	function automatic logic [TIMER_BITS-1:0] sat_load(logic [DELAY_W-1:0] ticks);
		logic [32:0] wide;
		logic [TIMER_BITS-1:0] v;
		wide = 33'(ticks);
		if (wide > 33'(TIMER_MAX)) begin
			v = TIMER_MAX;
		end else begin
			v = wide[TIMER_BITS-1:0];
		end
		return v;
	endfunction

endpackage

// ----- rtl/core/lsq_ifs.sv -----
// Channel interfaces of the lid sensor event qualifier.
// Input items, result items and config writes; depends on lsq_pkg.
interface lsq_in_if;
	logic valid;
	logic ready;
	logic op;
	logic sensor_level;
	modport source (output valid, op, sensor_level, input ready);
	modport sink (input valid, op, sensor_level, output ready);
endinterface

interface lsq_out_if;
	logic valid;
	logic ready;
	logic event_closed;
	logic lid_state;
	modport source (output valid, event_closed, lid_state, input ready);
	modport sink (input valid, event_closed, lid_state, output ready);
endinterface

interface lsq_cfg_if;
	logic valid;
	logic ready;
	logic [lsq_pkg::CFG_IDX_W-1:0] index;
	logic [lsq_pkg::DELAY_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/core/lsq_cfg_regs.sv -----
// Configuration register file of the lid sensor event qualifier.
// Takes write beats from the config channel; depends on lsq_pkg and lsq_ifs.
module lsq_cfg_regs (
	input  logic           clk,
	input  logic           arst_n,
	lsq_cfg_if.sink        cfg,
	output lsq_pkg::cfg_t  regs
);
	import lsq_pkg::*;

	cfg_t regs_q;
	logic wr_en;

	// Writes are always taken.
	assign cfg.ready = 1'b1;
	assign wr_en = cfg.valid;

	// Register write decode.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.enabled     <= 1'b1;
			regs_q.active_high <= 1'b0;
			regs_q.close_delay <= CLOSE_DELAY_RST;
			regs_q.hold_window <= HOLD_WINDOW_RST;
		end else if (wr_en) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_ENABLED:     regs_q.enabled     <= cfg.data[0];
				REG_ACTIVE_HIGH: regs_q.active_high <= cfg.data[0];
				REG_CLOSE_DELAY: regs_q.close_delay <= cfg.data;
				REG_HOLD_WINDOW: regs_q.hold_window <= cfg.data;
				default: ;
			endcase
		end
	end

	assign regs = regs_q;

endmodule

// ----- rtl/core/lsq_timer.sv -----
// One millisecond countdown with a pending flag, used for close and hold.
// Fires on the tick where the count reaches one or less; depends on lsq_pkg.
module lsq_timer (
	input  logic                           clk,
	input  logic                           arst_n,
	input  lsq_pkg::timer_ctl_t            ctl,
	input  logic [lsq_pkg::TIMER_BITS-1:0] load_val,
	output logic                           pending,
	output logic                           fire
);
	import lsq_pkg::*;

	logic                  pending_q;
	logic [TIMER_BITS-1:0] count_q;
	logic                  expire;

	// A pending count of one or zero expires on the next tick.
	assign expire = pending_q && (count_q <= TIMER_BITS'(1));
	assign fire = ctl.tick && expire;
	assign pending = pending_q;

	// Arm loads a fresh delay; clear drops it; tick counts down.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 1'b0;
			count_q   <= '0;
		end else if (ctl.arm) begin
			pending_q <= 1'b1;
			count_q   <= load_val;
		end else if (ctl.clear) begin
			pending_q <= 1'b0;
			count_q   <= '0;
		end else if (ctl.tick && pending_q) begin
			if (expire) begin
				pending_q <= 1'b0;
				count_q   <= '0;
			end else begin
				count_q <= count_q - TIMER_BITS'(1);
			end
		end
	end

endmodule

// ----- rtl/core/lid_sensor_event_qualifier.sv -----
// Lid sensor event qualifier: turns sensor edges and millisecond ticks into
// lid open and close events. An accepted input beat is held in the input
// register, then moves into the result register once that is free or
// draining. Throughput: one item per cycle, limited only by the result
// register draining. Reset: registers take their defaults (enabled, active
// low, 250, 3000); lid open, both countdowns idle. No clearing pass.
module lid_sensor_event_qualifier (
	input  logic      clk,
	input  logic      arst_n,
	lsq_in_if.sink    sensor,
	lsq_out_if.source events,
	lsq_cfg_if.sink   cfg
);
	import lsq_pkg::*;

	cfg_t regs;

	// Input stage.
	logic valid_s1;
	logic op_s1;
	logic level_s1;

	// Result register.
	logic out_valid_q;
	logic out_closed_q;
	logic out_lid_q;

	logic lid_closed_q;

	logic       advance;
	logic       is_tick;
	logic       edge_en;
	logic       reads_open;
	logic       open_evt;
	logic       close_pending;
	logic       close_fire;
	logic       hold_pending;
	logic       hold_fire;
	logic       has_result;
	logic       lid_next;
	timer_ctl_t close_ctl;
	timer_ctl_t hold_ctl;
	logic [TIMER_BITS-1:0] close_load;
	logic [TIMER_BITS-1:0] hold_load;

	lsq_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	// The held beat moves on once the result register is free or draining.
	assign advance = valid_s1 && (!out_valid_q || events.ready);
	assign sensor.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sensor.ready) begin
			valid_s1 <= sensor.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sensor.valid && sensor.ready) begin
			op_s1    <= sensor.op;
			level_s1 <= sensor.sensor_level;
		end
	end

	// Decode of the held beat against the current state.
	assign is_tick    = (op_s1 == OP_TICK);
	assign edge_en    = advance && !is_tick && regs.enabled;
	assign reads_open = (level_s1 != regs.active_high);
	assign open_evt   = edge_en && reads_open && !hold_pending;

	assign close_ctl.tick  = advance && is_tick;
	assign close_ctl.clear = edge_en;
	assign close_ctl.arm   = edge_en && !reads_open;
	assign close_load = sat_load(hold_pending ? regs.hold_window : regs.close_delay);

	assign hold_ctl.tick  = advance && is_tick;
	assign hold_ctl.clear = 1'b0;
	assign hold_ctl.arm   = edge_en && reads_open;
	assign hold_load = sat_load(regs.hold_window);

	lsq_timer u_close (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (close_ctl),
		.load_val (close_load),
		.pending  (close_pending),
		.fire     (close_fire)
	);

	lsq_timer u_hold (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (hold_ctl),
		.load_val (hold_load),
		.pending  (hold_pending),
		.fire     (hold_fire)
	);

	// Lid state after this beat.
	always_comb begin
		lid_next = lid_closed_q;
		if (close_fire) begin
			lid_next = 1'b1;
		end else if (open_evt) begin
			lid_next = 1'b0;
		end
	end

	assign has_result = close_fire || open_evt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lid_closed_q <= 1'b0;
		end else begin
			lid_closed_q <= lid_next;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= has_result;
		end else if (events.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_result) begin
			out_closed_q <= close_fire;
			out_lid_q    <= lid_next;
		end
	end

	assign events.valid        = out_valid_q;
	assign events.event_closed = out_closed_q;
	assign events.lid_state    = out_lid_q;

	// The reported lid state always matches the kind of event.
	a_lid_matches_event: assert property (@(posedge clk) disable iff (!arst_n)
		events.valid |-> (events.lid_state == events.event_closed))
		else $error("lid state does not match event kind");

	// An open event always starts the hold window.
	a_open_starts_hold: assert property (@(posedge clk) disable iff (!arst_n)
		open_evt |=> hold_pending)
		else $error("hold window not running after open event");

	// A close event leaves the lid closed.
	a_close_sets_lid: assert property (@(posedge clk) disable iff (!arst_n)
		close_fire |=> lid_closed_q)
		else $error("lid not closed after close event");

	// Input stalls only while a beat is held behind a stalled result.
	a_stall_reason: assert property (@(posedge clk) disable iff (!arst_n)
		!sensor.ready |-> (valid_s1 && out_valid_q && !events.ready))
		else $error("input stalled without a blocked result");

	// Hold countdown expiry never produces a result of its own.
	a_hold_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(hold_fire && !close_fire) |-> !open_evt)
		else $error("hold expiry coincides with an edge");

endmodule

// ----- tb/tb_lid_sensor_event_qualifier.sv -----
// Self-checking testbench for the lid sensor event qualifier.
// Drives edge and tick beats plus register writes, predicts lid events in a
// behavioral model and scoreboards them. Depends on lsq_pkg and lsq_ifs.
`timescale 1ns / 100ps

module tb_lid_sensor_event_qualifier;
	import lsq_pkg::*;

	localparam int RUN_LIMIT    = 200000;
	localparam int DRAIN_CYCLES = 8;
	localparam int LONG_HOLD    = 300;
	localparam int SEG_ITEMS    = 64;
	localparam int NUM_DIR      = 36;

	typedef struct packed {
		logic event_closed;
		logic lid_state;
	} lid_event_t;

	// One directed step: either a register write or an input beat, with an
	// optional hand-written expectation.
	typedef struct packed {
		logic               is_write;
		cfg_reg_t           idx;
		logic [DELAY_W-1:0] wdata;
		logic               op;
		logic               lvl;
		logic               typed;
		logic               has_evt;
		logic               evc;
		logic               lid;
	} step_row_t;

	logic clk = 1'b0;
	logic arst_n;

	lsq_in_if  sensor_ch ();
	lsq_out_if event_ch ();
	lsq_cfg_if cfg_ch ();

	lid_sensor_event_qualifier i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sensor (sensor_ch),
		.events (event_ch),
		.cfg    (cfg_ch)
	);

	// Lid state and countdowns as the block should hold them.
	cfg_t                  shadow;
	bit                    lid_closed;
	bit                    close_armed;
	bit                    hold_armed;
	logic [TIMER_BITS-1:0] close_left;
	logic [TIMER_BITS-1:0] hold_left;

	lid_event_t  pending_events[$];
	int unsigned mismatches;
	int unsigned cycle_count;
	int unsigned send_idle_pct;
	int unsigned rcv_stall_pct;
	logic        hold_req;
	logic        hold_ack;
	int unsigned hold_cycles;

	// Directed steps. Active low at first: level 1 reads open, level 0 closed.
	// Fields: write, reg, data, op, level, typed, has event, closed, lid.
	step_row_t dir_rows [NUM_DIR] = '{
		'{1'b0, REG_ENABLED,     16'd0,     OP_TICK, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0},
		'{1'b1, REG_CLOSE_DELAY, 16'd2,     OP_TICK, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b1, REG_HOLD_WINDOW, 16'd3,     OP_TICK, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b0, REG_ENABLED,     16'd0,     OP_EDGE, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0},
		'{1'b0, REG_ENABLED,     16'd0,     OP_EDGE, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b0, REG_ENABLED,     16'd0,     OP_EDGE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b0, REG_ENABLED,     16'd0,     OP_TICK, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b0, REG_ENABLED,     16'd0,     OP_TICK, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b0, REG_ENABLED,     16'd0,     OP_TICK, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b0, REG_ENABLED,     16'd0,     OP_EDGE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b0, REG_ENABLED,     16'd0,     OP_TICK, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b0, REG_ENABLED,     16'd0,     OP_TICK, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b0, REG_ENABLED,     16'd0,     OP_EDGE, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b0, REG_ENABLED,     16'd0,     OP_TICK, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b0, REG_ENABLED,     16'd0,     OP_TICK, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b0, REG_ENABLED,     16'd0,     OP_TICK, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b0, REG_ENABLED,     16'd0,     OP_EDGE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b0, REG_ENABLED,     16'd0,     OP_EDGE, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b1, REG_CLOSE_DELAY, 16'd0,     OP_TICK, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b1, REG_HOLD_WINDOW, 16'd0,     OP_TICK, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b0, REG_ENABLED,     16'd0,     OP_EDGE, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b0, REG_ENABLED,     16'd0,     OP_TICK, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b0, REG_ENABLED,     16'd0,     OP_EDGE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b1, REG_ENABLED,     16'hFFFE,  OP_TICK, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b0, REG_ENABLED,     16'd0,     OP_EDGE, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0},
		'{1'b0, REG_ENABLED,     16'd0,     OP_TICK, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b1, REG_ENABLED,     16'd1,     OP_TICK, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b1, REG_ACTIVE_HIGH, 16'd1,     OP_TICK, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b0, REG_ENABLED,     16'd0,     OP_EDGE, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b0, REG_ENABLED,     16'd0,     OP_EDGE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b1, REG_CLOSE_DELAY, 16'd65535, OP_TICK, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b1, REG_HOLD_WINDOW, 16'd65535, OP_TICK, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b0, REG_ENABLED,     16'd0,     OP_EDGE, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b0, REG_ENABLED,     16'd0,     OP_TICK, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b0, REG_ENABLED,     16'd0,     OP_EDGE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b0, REG_ENABLED,     16'd0,     OP_TICK, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0}
	};

	// Clock with an 8 ns period.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Delay as loaded into a countdown, clipped to what the counter can hold.
	function automatic logic [TIMER_BITS-1:0] load_timer(logic [DELAY_W-1:0] ticks);
		if (32'(ticks) > 32'(TIMER_MAX)) begin
			return TIMER_MAX;
		end else begin
			return TIMER_BITS'(ticks);
		end
	endfunction

	// Advance one countdown on a tick; true on the tick where it runs out.
	function automatic bit countdown_tick(inout bit armed, inout logic [TIMER_BITS-1:0] left);
		bit expired;
		expired = 1'b0;
		if (armed) begin
			if (left <= 1) begin
				armed = 1'b0;
				left = '0;
				expired = 1'b1;
			end else begin
				left = left - 1'b1;
			end
		end
		return expired;
	endfunction

	// Work out the event, if any, that one accepted beat causes.
	task automatic qualify_beat(input logic op, input logic lvl, output bit fired,
			output lid_event_t ev);
		bit close_done;
		fired = 1'b0;
		ev = '0;
		if (op == OP_TICK) begin
			close_done = countdown_tick(close_armed, close_left);
			void'(countdown_tick(hold_armed, hold_left));
			if (close_done) begin
				lid_closed = 1'b1;
				fired = 1'b1;
				ev.event_closed = 1'b1;
				ev.lid_state = lid_closed;
			end
		end else if (shadow.enabled) begin
			close_armed = 1'b0;
			close_left = '0;
			if (lvl != shadow.active_high) begin
				// Lid reads open: report only outside a running hold window.
				if (!hold_armed) begin
					lid_closed = 1'b0;
					fired = 1'b1;
					ev.event_closed = 1'b0;
					ev.lid_state = lid_closed;
				end
				hold_armed = 1'b1;
				hold_left = load_timer(shadow.hold_window);
			end else begin
				close_armed = 1'b1;
				close_left = load_timer(hold_armed ? shadow.hold_window : shadow.close_delay);
			end
		end
	endtask

	// Offer one beat, with random idle cycles first; valid stays high afterward.
	task automatic put_item(input logic op, input logic lvl, output bit fired,
			output lid_event_t ev);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			sensor_ch.valid <= 1'b0;
			@(posedge clk);
		end
		sensor_ch.valid <= 1'b1;
		sensor_ch.op <= op;
		sensor_ch.sensor_level <= lvl;
		do @(posedge clk); while (!sensor_ch.ready);
		qualify_beat(op, lvl, fired, ev);
	endtask

	// Random beats, ticks somewhat more often than edges.
	task automatic send_items(input int n);
		bit         fired;
		lid_event_t ev;
		logic       op;
		for (int i = 0; i < n; i++) begin
			op = ($urandom_range(0, 99) < 60) ? OP_TICK : OP_EDGE;
			put_item(op, 1'($urandom_range(0, 1)), fired, ev);
			if (fired) begin
				pending_events.push_back(ev);
			end
		end
	endtask

	// Stop sending and let every expected event and any work in flight finish.
	task automatic wait_idle();
		sensor_ch.valid <= 1'b0;
		while (pending_events.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// One register write; the shadow copy follows at the accepting edge.
	task automatic write_reg(input cfg_reg_t idx, input logic [DELAY_W-1:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		case (idx)
			REG_ENABLED: begin
				shadow.enabled = data[0];
			end
			REG_ACTIVE_HIGH: begin
				shadow.active_high = data[0];
			end
			REG_CLOSE_DELAY: begin
				shadow.close_delay = data;
			end
			REG_HOLD_WINDOW: begin
				shadow.hold_window = data;
			end
			default: begin
			end
		endcase
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	// Result side: ready follows the stall rate, or stays low for a long hold.
	always @(posedge clk) begin
		if (hold_req != hold_ack) begin
			hold_ack <= hold_req;
			hold_cycles <= LONG_HOLD;
			event_ch.ready <= 1'b0;
		end else if (hold_cycles != 0) begin
			hold_cycles <= hold_cycles - 1;
			event_ch.ready <= 1'b0;
		end else begin
			event_ch.ready <= ($urandom_range(0, 99) >= rcv_stall_pct);
		end
	end

	// Scoreboard: each event beat against the oldest expectation.
	always @(posedge clk) begin
		lid_event_t got;
		if (arst_n && event_ch.valid && event_ch.ready) begin
			got.event_closed = event_ch.event_closed;
			got.lid_state = event_ch.lid_state;
			if (pending_events.size() == 0) begin
				$display("%0t: unexpected event: event_closed=%0b lid_state=%0b",
					$time, got.event_closed, got.lid_state);
				mismatches++;
			end else begin
				if (got !== pending_events[0]) begin
					$display("%0t: event mismatch: expected event_closed=%0b lid_state=%0b, got event_closed=%0b lid_state=%0b",
						$time, pending_events[0].event_closed, pending_events[0].lid_state,
						got.event_closed, got.lid_state);
					mismatches++;
				end
				void'(pending_events.pop_front());
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == RUN_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Stimulus: reset, directed steps, random phases, then the long hold.
	initial begin
		bit         fired;
		lid_event_t ev;
		int         kind;
		logic [DELAY_W-1:0] close_val;
		logic [DELAY_W-1:0] hold_val;
		logic               en_val;

		arst_n = 1'b0;
		sensor_ch.valid = 1'b0;
		sensor_ch.op = OP_EDGE;
		sensor_ch.sensor_level = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_ENABLED;
		cfg_ch.data = '0;
		event_ch.ready = 1'b0;
		hold_req = 1'b0;
		hold_ack = 1'b0;
		hold_cycles = 0;
		send_idle_pct = 0;
		rcv_stall_pct = 0;
		mismatches = 0;
		cycle_count = 0;
		shadow = '{enabled: 1'b1, active_high: 1'b0,
			close_delay: CLOSE_DELAY_RST, hold_window: HOLD_WINDOW_RST};
		lid_closed = 1'b0;
		close_armed = 1'b0;
		hold_armed = 1'b0;
		close_left = '0;
		hold_left = '0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed steps; typed rows carry their own expectation.
		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_write) begin
				wait_idle();
				write_reg(dir_rows[i].idx, dir_rows[i].wdata);
			end else begin
				put_item(dir_rows[i].op, dir_rows[i].lvl, fired, ev);
				if (dir_rows[i].typed) begin
					if (dir_rows[i].has_evt) begin
						pending_events.push_back('{event_closed: dir_rows[i].evc,
							lid_state: dir_rows[i].lid});
					end
				end else if (fired) begin
					pending_events.push_back(ev);
				end
			end
		end

		// Random phases, each under its own idling pattern and several settings.
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					send_idle_pct = 0;
					rcv_stall_pct <= 0;
				end
				1: begin
					send_idle_pct = 61;
					rcv_stall_pct <= 0;
				end
				2: begin
					send_idle_pct = 0;
					rcv_stall_pct <= 61;
				end
				default: begin
					send_idle_pct = 27;
					rcv_stall_pct <= 27;
				end
			endcase
			for (int seg = 0; seg < 4; seg++) begin
				kind = (ph * 4 + seg) % 6;
				close_val = DELAY_W'($urandom_range(0, 8));
				hold_val = DELAY_W'($urandom_range(0, 8));
				en_val = (kind == 3) ? 1'b0 : 1'b1;
				case (kind)
					0: begin
						close_val = '0;
						hold_val = '0;
					end
					1: begin
						close_val = '1;
					end
					2: begin
						hold_val = '1;
					end
					default: begin
					end
				endcase
				wait_idle();
				// Upper data bits of the one-bit registers carry random junk.
				write_reg(REG_ENABLED, {15'($urandom_range(0, 32767)), en_val});
				write_reg(REG_ACTIVE_HIGH,
					{15'($urandom_range(0, 32767)), 1'($urandom_range(0, 1))});
				write_reg(REG_CLOSE_DELAY, close_val);
				write_reg(REG_HOLD_WINDOW, hold_val);
				send_items(SEG_ITEMS);
			end
		end

		// Long receiver hold while the sender keeps offering, so the block backs up.
		wait_idle();
		write_reg(REG_ENABLED, 16'd1);
		write_reg(REG_CLOSE_DELAY, 16'd0);
		write_reg(REG_HOLD_WINDOW, 16'd0);
		send_idle_pct = 0;
		rcv_stall_pct <= 0;
		hold_req <= ~hold_req;
		send_items(120);

		// The sender pauses until every expected event is back.
		wait_idle();

		if (mismatches == 0 && pending_events.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/core/lsq_pkg.sv
rtl/core/lsq_ifs.sv
rtl/core/lsq_cfg_regs.sv
rtl/core/lsq_timer.sv
rtl/core/lid_sensor_event_qualifier.sv
tb/tb_lid_sensor_event_qualifier.sv
